// ----- hdl/chs_pkg.sv -----
// Shared types, constants and speed helpers for the coaxial helicopter stabilizer.
// Used by coaxial_heli_stabilizer, chs_sample_checker and the testbench; no dependencies.
`default_nettype none
package chs_pkg;

    localparam int GYRO_WINDOW_LOG_DEF  = 5;
    localparam int ACCEL_WINDOW_LOG_DEF = 7;
    localparam int STEPS_PER_SECOND_DEF = 10;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int SPEED_W    = 16;
    localparam int STAB_OUT_W = 15;
    localparam int SAMPLE_W   = 8;

    typedef enum logic [1:0] {
        PH_GROUND  = 2'd0,
        PH_LANDING = 2'd1,
        PH_TAKEOFF = 2'd2,
        PH_HOVER   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAKEOFF_END = 3'd0,
        CFG_HOVER       = 3'd1,
        CFG_LANDING     = 3'd2,
        CFG_DESCENT_END = 3'd3,
        CFG_GROUND      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CH_GYRO = 2'd0,
        CH_X    = 2'd1,
        CH_Y    = 2'd2,
        CH_Z    = 2'd3
    } chan_t;

    localparam logic [CFG_W-1:0] TAKEOFF_END_RST = 12'd5;
    localparam logic [CFG_W-1:0] HOVER_RST       = 12'd23;
    localparam logic [CFG_W-1:0] LANDING_RST     = 12'd299;
    localparam logic [CFG_W-1:0] DESCENT_END_RST = 12'd400;
    localparam logic [CFG_W-1:0] GROUND_RST      = 12'd410;
    localparam logic [CFG_W-1:0] SECONDS_MAX     = 12'd4095;

    // 8.8 fixed point limits
    localparam logic signed [SPEED_W-1:0] ROTOR_MAX = 16'sd25600;
    localparam logic signed [SPEED_W-1:0] ROTOR_Z   = 16'sd24832;
    localparam logic signed [SPEED_W-1:0] ROTOR_TO  = 16'sd24320;
    localparam logic signed [SPEED_W-1:0] ROTOR_MIN = 16'sd12800;
    localparam logic signed [SPEED_W-1:0] STAB_MAX  = 16'sd15360;

    function automatic logic signed [SPEED_W-1:0] dec_if_pos(
        input logic signed [SPEED_W-1:0] v,
        input logic signed [SPEED_W-1:0] by
    );
        return (v > 16'sd0) ? v - by : v;
    endfunction

    function automatic logic signed [SPEED_W-1:0] inc_if_below(
        input logic signed [SPEED_W-1:0] v,
        input logic signed [SPEED_W-1:0] lim,
        input logic signed [SPEED_W-1:0] by
    );
        return (v < lim) ? v + by : v;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/coaxial_heli_stabilizer.sv -----
// Top level of the coaxial helicopter stabilizer: window filter, dead-zone rules, schedule.
// Depends on chs_pkg and chs_ram.
//
// Usage:
//   Input channel s_*: one request per sensor sample. s_tdata carries the signed
//   sample, s_tuser carries the kind (calibration/flight) and the channel.
//   Output channel m_*: one request per accepted sample with all motor speeds,
//   the flight phase, the seconds count and the window mean of the channel.
//   Config port: cfg_we/cfg_index/cfg_data writes one schedule register per cycle;
//   write only while no sample is in flight. Unknown indexes are dropped.
// Timing:
//   An item passes a read stage and an update stage: the read stage reads the
//   oldest sample of the channel's window from the window RAM, the update stage
//   updates the sum, writes the new sample back and registers the result. A new
//   sample is taken only once the current one commits, as the single window RAM is read ahead of its write.
// Stall:
//   A result waits in the output register while m_tready is low; the next sample
//   is accepted meanwhile and holds in its read stage until the register frees.
// Reset:
//   All windows read as zero after reset through per-channel full flags, so no
//   clearing pass is needed; speeds, counters and references clear, phase is ground.
`default_nettype none
module coaxial_heli_stabilizer #(
    parameter int GYRO_WINDOW_LOG  = chs_pkg::GYRO_WINDOW_LOG_DEF,
    parameter int ACCEL_WINDOW_LOG = chs_pkg::ACCEL_WINDOW_LOG_DEF,
    parameter int STEPS_PER_SECOND = chs_pkg::STEPS_PER_SECOND_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] sample
    input  wire  [2:0]   s_tuser,   // [0] kind, [2:1] channel
    output logic         m_tvalid,
    input  wire          m_tready,
    // [15:0] top_speed, [31:16] bottom_speed, [46:32] front_speed, [61:47] right_speed,
    // [76:62] left_speed, [78:77] flight_phase, [90:79] elapsed_seconds,
    // [98:91] window_mean, [103:99] zero
    output logic [103:0] m_tdata,
    input  wire          cfg_we,
    input  wire  [2:0]   cfg_index,
    input  wire  [11:0]  cfg_data
);

    localparam int MAXLOG = (GYRO_WINDOW_LOG > ACCEL_WINDOW_LOG) ?
                            GYRO_WINDOW_LOG : ACCEL_WINDOW_LOG;
    localparam int PW    = MAXLOG;
    localparam int AW    = PW + 2;
    localparam int DEPTH = 4 << PW;
    localparam int SW    = chs_pkg::SAMPLE_W + MAXLOG;
    localparam int SCW   = $clog2(STEPS_PER_SECOND + 1);
    localparam int SPW   = chs_pkg::SPEED_W;
    localparam logic [PW-1:0] GMASK = PW'((1 << GYRO_WINDOW_LOG) - 1);
    localparam logic [PW-1:0] AMASK = PW'((1 << ACCEL_WINDOW_LOG) - 1);
    localparam logic [SCW-1:0] STEPS = SCW'(STEPS_PER_SECOND);

    // configuration
    logic [11:0] takeoff_reg, hover_reg, landing_reg, descent_reg, ground_reg;

    // pipeline control and captured request
    logic        busy_reg;
    logic        kind_reg;
    logic [1:0]  ch_reg;
    logic signed [7:0] smp_reg;

    // per-channel state
    logic [PW-1:0]        ptr_reg  [4];
    logic [3:0]           full_reg;
    logic signed [SW-1:0] sum_reg  [4];
    logic signed [7:0]    ref_reg  [4];

    logic signed [SPW-1:0] top_reg, bot_reg, m1_reg, m2_reg, m3_reg;
    chs_pkg::phase_t       phase_reg, phase_next;
    logic [11:0]           sec_reg, sec_next;
    logic [SCW-1:0]        step_reg, step_next;

    logic signed [SPW-1:0] top_next, bot_next, m1_next, m2_next, m3_next;

    // output register
    logic          out_valid_reg;
    logic [103:0]  out_data_reg;

    logic          accept, commit, shift;
    logic [7:0]    rdata;
    logic signed [7:0]    oldest;
    logic signed [SW-1:0] sum_new, sum_use, sum_sh;
    logic signed [7:0]    mean;
    logic signed [9:0]    m_x, r_x;
    logic [PW-1:0]        ptr_cur, ptr_inc;
    logic [1:0]           s_ch;

    assign s_ch     = s_tuser[2:1];
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign commit   = busy_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    chs_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_window_ram (
        .clk  (clk),
        .we   (commit && shift),
        .waddr({ch_reg, ptr_cur}),
        .wdata(smp_reg),
        .re   (accept),
        .raddr({s_ch, ptr_reg[s_ch]}),
        .rdata(rdata)
    );

    // window update: unwritten slots count as zero until the pointer wraps
    always_comb
    begin
        ptr_cur = ptr_reg[ch_reg];
        ptr_inc = (ptr_cur + PW'(1)) & ((ch_reg == 2'(chs_pkg::CH_GYRO)) ? GMASK : AMASK);
        oldest  = full_reg[ch_reg] ? $signed(rdata) : 8'sd0;
        shift   = !kind_reg || (ch_reg == 2'(chs_pkg::CH_GYRO)) ||
                  (phase_reg == chs_pkg::PH_HOVER);
        sum_new = sum_reg[ch_reg] + SW'(smp_reg) - SW'(oldest);
        sum_use = shift ? sum_new : sum_reg[ch_reg];
        sum_sh  = (ch_reg == 2'(chs_pkg::CH_GYRO)) ? (sum_use >>> GYRO_WINDOW_LOG) :
                                                     (sum_use >>> ACCEL_WINDOW_LOG);
        mean    = sum_sh[7:0];
        m_x     = 10'(mean);
        r_x     = 10'(ref_reg[ch_reg]);
    end

    // flight rules, then schedule, then step/second advance
    always_comb
    begin
        logic [12:0] s13;
        top_next   = top_reg;
        bot_next   = bot_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        m3_next    = m3_reg;
        phase_next = phase_reg;
        sec_next   = sec_reg;
        step_next  = step_reg;
        s13        = {1'b0, sec_reg};
        if (kind_reg)
        begin
            case (ch_reg)
                2'(chs_pkg::CH_GYRO):
                begin
                    if (m_x < r_x - 10'sd1)
                    begin
                        top_next = chs_pkg::inc_if_below(top_next, chs_pkg::ROTOR_MAX, 16'sd8);
                        bot_next = chs_pkg::dec_if_pos(bot_next, 16'sd8);
                    end
                    else if (m_x > r_x + 10'sd1)
                    begin
                        top_next = chs_pkg::dec_if_pos(top_next, 16'sd8);
                        bot_next = chs_pkg::inc_if_below(bot_next, chs_pkg::ROTOR_MAX, 16'sd8);
                    end
                end
                2'(chs_pkg::CH_X):
                begin
                    if (phase_reg == chs_pkg::PH_HOVER)
                    begin
                        if (m_x < r_x)
                        begin
                            m1_next = chs_pkg::dec_if_pos(m1_next, 16'sd512);
                            m2_next = chs_pkg::inc_if_below(m2_next, chs_pkg::STAB_MAX, 16'sd512);
                            m3_next = chs_pkg::inc_if_below(m3_next, chs_pkg::STAB_MAX, 16'sd512);
                        end
                        else if (m_x > r_x + 10'sd1)
                        begin
                            m1_next = chs_pkg::inc_if_below(m1_next, chs_pkg::STAB_MAX, 16'sd512);
                            m2_next = chs_pkg::dec_if_pos(m2_next, 16'sd512);
                            m3_next = chs_pkg::dec_if_pos(m3_next, 16'sd512);
                        end
                        else
                        begin
                            m1_next = chs_pkg::dec_if_pos(m1_next, 16'sd512);
                        end
                    end
                end
                2'(chs_pkg::CH_Y):
                begin
                    if (phase_reg == chs_pkg::PH_HOVER)
                    begin
                        if (m_x < r_x)
                        begin
                            m2_next = chs_pkg::inc_if_below(m2_next, chs_pkg::STAB_MAX, 16'sd1024);
                            m3_next = chs_pkg::dec_if_pos(m3_next, 16'sd512);
                        end
                        else if (m_x > r_x)
                        begin
                            m2_next = chs_pkg::dec_if_pos(m2_next, 16'sd512);
                            m3_next = chs_pkg::inc_if_below(m3_next, chs_pkg::STAB_MAX, 16'sd1024);
                        end
                        else
                        begin
                            m2_next = chs_pkg::dec_if_pos(m2_next, 16'sd256);
                            m3_next = chs_pkg::dec_if_pos(m3_next, 16'sd256);
                        end
                    end
                end
                default:
                begin
                    if (phase_reg == chs_pkg::PH_HOVER)
                    begin
                        if (m_x > r_x + 10'sd3)
                        begin
                            top_next = chs_pkg::dec_if_pos(top_next, 16'sd2);
                            bot_next = chs_pkg::dec_if_pos(bot_next, 16'sd2);
                        end
                        else if (m_x == r_x)
                        begin
                            top_next = chs_pkg::inc_if_below(top_next, chs_pkg::ROTOR_Z, 16'sd5);
                            bot_next = chs_pkg::inc_if_below(bot_next, chs_pkg::ROTOR_Z, 16'sd5);
                        end
                    end
                end
            endcase

            // schedule on the second count before this step's advance
            if (sec_reg <= takeoff_reg)
            begin
                phase_next = chs_pkg::PH_TAKEOFF;
                top_next = chs_pkg::inc_if_below(top_next, chs_pkg::ROTOR_TO, 16'sd16);
                bot_next = chs_pkg::inc_if_below(bot_next, chs_pkg::ROTOR_TO, 16'sd16);
            end
            if (sec_reg == hover_reg)
            begin
                phase_next = chs_pkg::PH_HOVER;
            end
            if (sec_reg == landing_reg)
            begin
                phase_next = chs_pkg::PH_LANDING;
                m1_next = '0;
                m2_next = '0;
                m3_next = '0;
            end
            if (s13 > {1'b0, landing_reg} && sec_reg <= descent_reg)
            begin
                if (top_next > chs_pkg::ROTOR_MIN)
                begin
                    top_next = top_next - 16'sd1;
                end
                if (bot_next > chs_pkg::ROTOR_MIN)
                begin
                    bot_next = bot_next - 16'sd1;
                end
            end
            if (sec_reg >= ground_reg)
            begin
                phase_next = chs_pkg::PH_GROUND;
            end

            step_next = step_reg + SCW'(1);
            if (step_next >= STEPS)
            begin
                step_next = '0;
                if (sec_reg != chs_pkg::SECONDS_MAX)
                begin
                    sec_next = sec_reg + 12'd1;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            takeoff_reg <= chs_pkg::TAKEOFF_END_RST;
            hover_reg   <= chs_pkg::HOVER_RST;
            landing_reg <= chs_pkg::LANDING_RST;
            descent_reg <= chs_pkg::DESCENT_END_RST;
            ground_reg  <= chs_pkg::GROUND_RST;
        end
        else if (cfg_we)
        begin
            case (chs_pkg::cfg_idx_t'(cfg_index))
                chs_pkg::CFG_TAKEOFF_END: takeoff_reg <= cfg_data;
                chs_pkg::CFG_HOVER:       hover_reg   <= cfg_data;
                chs_pkg::CFG_LANDING:     landing_reg <= cfg_data;
                chs_pkg::CFG_DESCENT_END: descent_reg <= cfg_data;
                chs_pkg::CFG_GROUND:      ground_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // capture the request while the oldest sample is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser[0];
            ch_reg   <= s_ch;
            smp_reg  <= $signed(s_tdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            full_reg      <= '0;
            top_reg       <= '0;
            bot_reg       <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            m3_reg        <= '0;
            phase_reg     <= chs_pkg::PH_GROUND;
            sec_reg       <= '0;
            step_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                ptr_reg[i] <= '0;
                sum_reg[i] <= '0;
                ref_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                if (shift)
                begin
                    ptr_reg[ch_reg] <= ptr_inc;
                    sum_reg[ch_reg] <= sum_new;
                    if (ptr_inc == '0)
                    begin
                        full_reg[ch_reg] <= 1'b1;
                    end
                end
                if (!kind_reg)
                begin
                    ref_reg[ch_reg] <= mean;
                end
                top_reg   <= top_next;
                bot_reg   <= bot_next;
                m1_reg    <= m1_next;
                m2_reg    <= m2_next;
                m3_reg    <= m3_next;
                phase_reg <= phase_next;
                sec_reg   <= sec_next;
                step_reg  <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {5'd0, mean, sec_next, phase_next,
                             m3_next[14:0], m2_next[14:0], m1_next[14:0],
                             bot_next, top_next};
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted request did not enter the read stage");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed result missing from output register");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result lost or changed");
    a_sec_mono: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg >= $past(sec_reg))
        else $error("seconds count went backwards");
    a_no_read_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !accept)
        else $error("window read issued over a pending update");
`endif

endmodule
`default_nettype wire

// ----- hdl/chs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- dv/chs_sample_checker.sv -----
// Checker for the coaxial helicopter stabilizer: watches the sample, result and
// config channels, predicts every result and compares it field by field.
// Depends on chs_pkg for phase, channel and register codes.
module chs_sample_checker
    import chs_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [7:0]   s_tdata,
    input  wire  [2:0]   s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [103:0] m_tdata,
    input  wire          cfg_we,
    input  wire  [2:0]   cfg_index,
    input  wire  [11:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    localparam int GYRO_LEN  = 1 << GYRO_WINDOW_LOG_DEF;
    localparam int ACCEL_LEN = 1 << ACCEL_WINDOW_LOG_DEF;

    typedef struct packed {
        logic [15:0] top;
        logic [15:0] bottom;
        logic [14:0] front;
        logic [14:0] right;
        logic [14:0] left;
        logic [1:0]  phase;
        logic [11:0] seconds;
        logic [7:0]  mean;
    } motor_state_t;

    motor_state_t expected_states[$];

    logic signed [7:0] gyro_win[GYRO_LEN];
    logic signed [7:0] accel_win[3][ACCEL_LEN];
    int     win_sum[4];
    int     ref_level[4];
    int     rotor[2];
    int     stab[3];
    phase_t phase;
    int     seconds;
    int     steps;
    int     sched[5];

    initial
    begin
        fail_count = 0;
        foreach (gyro_win[i]) gyro_win[i] = '0;
        foreach (accel_win[c, i]) accel_win[c][i] = '0;
        foreach (win_sum[i]) win_sum[i] = 0;
        foreach (ref_level[i]) ref_level[i] = 0;
        rotor = '{0, 0};
        stab = '{0, 0, 0};
        phase = PH_GROUND;
        seconds = 0;
        steps = 0;
        sched = '{int'(TAKEOFF_END_RST), int'(HOVER_RST), int'(LANDING_RST),
                  int'(DESCENT_END_RST), int'(GROUND_RST)};
    end

    assign pending = expected_states.size();

    function automatic int window_mean(int ch);
        if (ch == CH_GYRO)
            return win_sum[ch] >>> GYRO_WINDOW_LOG_DEF;
        return win_sum[ch] >>> ACCEL_WINDOW_LOG_DEF;
    endfunction

    // Drop the oldest sample of the window and push the new one.
    function automatic void push_sample(int ch, logic signed [7:0] s);
        if (ch == CH_GYRO)
        begin
            win_sum[ch] += int'(s) - int'(gyro_win[0]);
            for (int i = 0; i < GYRO_LEN - 1; i++) gyro_win[i] = gyro_win[i + 1];
            gyro_win[GYRO_LEN - 1] = s;
        end
        else
        begin
            win_sum[ch] += int'(s) - int'(accel_win[ch - 1][0]);
            for (int i = 0; i < ACCEL_LEN - 1; i++)
                accel_win[ch - 1][i] = accel_win[ch - 1][i + 1];
            accel_win[ch - 1][ACCEL_LEN - 1] = s;
        end
    endfunction

    function automatic void lower(ref int v, input int by);
        if (v > 0) v -= by;
    endfunction

    function automatic void raise(ref int v, input int lim, input int by);
        if (v < lim) v += by;
    endfunction

    function automatic void advance_schedule();
        int s;
        s = seconds;
        if (s <= sched[CFG_TAKEOFF_END])
        begin
            phase = PH_TAKEOFF;
            raise(rotor[0], ROTOR_TO, 16);
            raise(rotor[1], ROTOR_TO, 16);
        end
        if (s == sched[CFG_HOVER])
            phase = PH_HOVER;
        if (s == sched[CFG_LANDING])
        begin
            phase = PH_LANDING;
            stab = '{0, 0, 0};
        end
        if (s >= sched[CFG_LANDING] + 1 && s <= sched[CFG_DESCENT_END])
        begin
            if (rotor[0] > ROTOR_MIN) rotor[0] -= 1;
            if (rotor[1] > ROTOR_MIN) rotor[1] -= 1;
        end
        if (s >= sched[CFG_GROUND])
            phase = PH_GROUND;
    endfunction

    function automatic motor_state_t predict_motors(logic flight, int ch,
                                                    logic signed [7:0] s);
        int m;
        int r;
        motor_state_t res;
        if (!flight)
        begin
            push_sample(ch, s);
            ref_level[ch] = window_mean(ch);
        end
        else
        begin
            r = ref_level[ch];
            if (ch == CH_GYRO)
            begin
                push_sample(ch, s);
                m = window_mean(ch);
                if (m < r - 1)
                begin
                    raise(rotor[0], ROTOR_MAX, 8);
                    lower(rotor[1], 8);
                end
                else if (m > r + 1)
                begin
                    lower(rotor[0], 8);
                    raise(rotor[1], ROTOR_MAX, 8);
                end
            end
            else if (phase == PH_HOVER)
            begin
                push_sample(ch, s);
                m = window_mean(ch);
                if (ch == CH_X)
                begin
                    if (m < r)
                    begin
                        lower(stab[0], 512);
                        raise(stab[1], STAB_MAX, 512);
                        raise(stab[2], STAB_MAX, 512);
                    end
                    else if (m > r + 1)
                    begin
                        raise(stab[0], STAB_MAX, 512);
                        lower(stab[1], 512);
                        lower(stab[2], 512);
                    end
                    else
                        lower(stab[0], 512);
                end
                else if (ch == CH_Y)
                begin
                    if (m < r)
                    begin
                        raise(stab[1], STAB_MAX, 1024);
                        lower(stab[2], 512);
                    end
                    else if (m > r)
                    begin
                        lower(stab[1], 512);
                        raise(stab[2], STAB_MAX, 1024);
                    end
                    else
                    begin
                        lower(stab[1], 256);
                        lower(stab[2], 256);
                    end
                end
                else
                begin
                    if (m > r + 3)
                    begin
                        lower(rotor[0], 2);
                        lower(rotor[1], 2);
                    end
                    else if (m == r)
                    begin
                        raise(rotor[0], ROTOR_Z, 5);
                        raise(rotor[1], ROTOR_Z, 5);
                    end
                end
            end
            advance_schedule();
            steps++;
            if (steps >= STEPS_PER_SECOND_DEF)
            begin
                steps = 0;
                if (seconds < int'(SECONDS_MAX)) seconds++;
            end
        end
        res.top     = rotor[0][15:0];
        res.bottom  = rotor[1][15:0];
        res.front   = stab[0][14:0];
        res.right   = stab[1][14:0];
        res.left    = stab[2][14:0];
        res.phase   = phase;
        res.seconds = seconds[11:0];
        res.mean    = 8'(window_mean(ch));
        return res;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        motor_state_t want;
        motor_state_t got;
        if (rst_n)
        begin
            if (cfg_we && cfg_index < 3'd5)
                sched[cfg_index] = int'(cfg_data);
            if (s_tvalid && s_tready)
                expected_states.push_back(predict_motors(s_tuser[0], int'(s_tuser[2:1]),
                                                         s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[46:32], m_tdata[61:47],
                       m_tdata[76:62], m_tdata[78:77], m_tdata[90:79], m_tdata[98:91]};
                if (expected_states.size() == 0)
                begin
                    // a result with no request waiting for it
                    report_mismatch("queued requests", 1, 0);
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (want.top != got.top) report_mismatch("top", want.top, got.top);
                    if (want.bottom != got.bottom)
                        report_mismatch("bottom", want.bottom, got.bottom);
                    if (want.front != got.front)
                        report_mismatch("front", want.front, got.front);
                    if (want.right != got.right)
                        report_mismatch("right", want.right, got.right);
                    if (want.left != got.left) report_mismatch("left", want.left, got.left);
                    if (want.phase != got.phase)
                        report_mismatch("phase", want.phase, got.phase);
                    if (want.seconds != got.seconds)
                        report_mismatch("seconds", want.seconds, got.seconds);
                    if (want.mean != got.mean) report_mismatch("mean", want.mean, got.mean);
                    if (m_tdata[103:99] != 5'd0)
                        report_mismatch("pad", 0, m_tdata[103:99]);
                end
            end
        end
    end

endmodule

// ----- dv/coaxial_heli_stabilizer_test.sv -----
// Testbench top for the coaxial helicopter stabilizer: drives samples, schedule
// writes and output backpressure; chs_sample_checker predicts and compares.
// Depends on chs_pkg, the block and chs_sample_checker.
module coaxial_heli_stabilizer_test;
    import chs_pkg::*;

    // index past the register file; the block must drop writes to it
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam logic KIND_CAL = 1'b0;
    localparam logic KIND_FLIGHT = 1'b1;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic  [7:0]   s_tdata = '0;   // [7:0] sample
    logic  [2:0]   s_tuser = '0;   // [0] kind, [2:1] channel
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic  [103:0] m_tdata;        // speeds, phase, seconds, mean; see block header
    logic          cfg_we = 1'b0;
    logic  [2:0]   cfg_index = '0;
    logic  [11:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int flights_sent = 0;
    int results_taken = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;

    always #5 clk = ~clk;

    coaxial_heli_stabilizer u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    chs_sample_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall before each result while gaps are on, one long hold-off so the
    // block backs up and stalls its input.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = gaps_on ? $urandom_range(3, 0) : 0;
            if (results_taken == 150)
                hold = 60;
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
        end
    end

    // Offer one sample request and hold it until the block takes it.
    task automatic send_sample(logic kind, chan_t ch, logic [7:0] s);
        int gap;
        gap = gaps_on ? $urandom_range(3, 0) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= {ch, kind};
        do @(posedge clk); while (!s_tready);
        if (kind == KIND_FLIGHT)
            flights_sent++;
    endtask

    // Drop valid, let the checker queue the last request, wait for every
    // result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[11:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_schedule(int t_end, int hov, int land, int d_end, int gnd);
        write_reg(CFG_TAKEOFF_END, t_end);
        write_reg(CFG_HOVER, hov);
        write_reg(CFG_LANDING, land);
        write_reg(CFG_DESCENT_END, d_end);
        write_reg(CFG_GROUND, gnd);
        @(posedge clk);
    endtask

    // Mostly flight samples near the reference so the dead zones are hit,
    // some calibration and full-range readings.
    task automatic random_samples(int count);
        logic       kind;
        logic [7:0] s;
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(9, 0) < 8) ? KIND_FLIGHT : KIND_CAL;
            if ($urandom_range(9, 0) < 7)
                s = 8'($signed($urandom_range(12, 0)) - 6);
            else
                s = 8'($urandom);
            send_sample(kind, chan_t'($urandom_range(3, 0)), s);
        end
    endtask

    initial
    begin
        int base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: calibration extremes on every channel, gyro flight both
        // ways, accel flight samples outside hover that must leave windows alone.
        for (int c = 0; c < 4; c++)
        begin
            send_sample(KIND_CAL, chan_t'(c), 8'h7F);
            send_sample(KIND_CAL, chan_t'(c), 8'h80);
        end
        send_sample(KIND_FLIGHT, CH_GYRO, 8'h80);
        send_sample(KIND_FLIGHT, CH_GYRO, 8'h80);
        send_sample(KIND_FLIGHT, CH_GYRO, 8'h7F);
        send_sample(KIND_FLIGHT, CH_GYRO, 8'h7F);
        send_sample(KIND_FLIGHT, CH_GYRO, 8'h7F);
        send_sample(KIND_FLIGHT, CH_X, 8'h55);
        send_sample(KIND_FLIGHT, CH_Y, 8'hAA);
        send_sample(KIND_FLIGHT, CH_Z, 8'h7F);
        for (int c = 0; c < 4; c++)
            send_sample(KIND_CAL, chan_t'(c), 8'h00);
        drain();

        // Dropped write, then a short flight with hover, landing and descent.
        write_reg(CFG_UNUSED, 12'hFFF);
        base = flights_sent / 10;
        write_schedule(base, base + 1, base + 25, base + 32, base + 36);
        random_samples(330);
        drain();

        // Second flight, first 120 samples with no idling on either side.
        base = flights_sent / 10;
        write_schedule(base + 1, base + 2, base + 20, base + 24, base + 27);
        gaps_on = 1'b0;
        random_samples(120);
        gaps_on = 1'b1;
        random_samples(150);
        drain();

        // Register extremes: always ground, then always takeoff.
        write_schedule(0, 0, 0, 0, 0);
        random_samples(100);
        drain();
        write_schedule(4095, 4095, 4095, 4095, 4095);
        random_samples(100);
        drain();

        // Long descent over the rest of the run.
        write_schedule(0, 0, 0, 4095, 4095);
        random_samples(80);
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
